/* rtl/assert_macros.svh */
// Concurrent assertion macros shared by the pedal speed gain core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/psfg_pkg.sv */
// Types and constants shared by the pedal speed gain core and its units.
package psfg_pkg;

    // request operations (tuser)
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_WR_SPRING = 2'd1;
    localparam logic [1:0] OP_WR_DAMPER = 2'd2;

    // configuration register indexes
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;
    localparam logic [CFG_AW-1:0] CFG_PEDAL_INVERT = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_THR_MAX      = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_BRK_MAX      = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_GROUND       = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DRAG         = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_MAX_SPEED    = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_SPRING_GAIN  = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_DAMPER_GAIN  = 3'd7;

    // register reset values
    localparam logic [15:0] RST_THR_MAX   = 16'd2370;
    localparam logic [15:0] RST_BRK_MAX   = 16'd4000;
    localparam logic [15:0] RST_GROUND    = 16'd50;
    localparam logic [15:0] RST_DRAG      = 16'd4521;
    localparam logic [15:0] RST_MAX_SPEED = 16'd24889;
    localparam logic [10:0] RST_GAIN      = 11'd1024;

    localparam int ENTRY_W = 11;
    localparam int COEF_W  = 14;
    localparam logic [COEF_W-1:0] COEF_FULL = 14'd10000;

    // speed update: divide by 200*2^16, rounded, floor on negatives
    localparam logic [15:0] TICK_HZ   = 16'd200;
    localparam logic [34:0] HALF_STEP = 35'd6553600;   // 100 * 2^16
    localparam logic [17:0] DIV_BIAS  = 18'd2048;      // keeps dividend positive
    localparam logic [19:0] BIAS_NUM  = 20'd409600;    // DIV_BIAS * 200

    localparam logic [4:0] PAIRS_PEDAL = 5'd16;        // 32 quotient bits
    localparam logic [4:0] PAIRS_SHORT = 5'd7;         // 14 quotient bits

    typedef struct packed {
        logic        start;
        logic [15:0] rem_init;
        logic [31:0] low;
        logic [4:0]  pairs;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;

endpackage

/* rtl/psfg_ram.sv */
// Generic simple dual-port RAM with registered read.
module psfg_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1001
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/psfg_div.sv */
// Shared serial divider, two quotient bits per cycle, preloaded remainder.
`include "assert_macros.svh"

module psfg_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psfg_pkg::t_div_req i_req,
    output psfg_pkg::t_div_rsp o_rsp
);
    import psfg_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [31:0] r_low;
    logic [31:0] r_quo;
    logic [15:0] r_div;

    logic [16:0] w_x1;
    logic [16:0] w_r1;
    logic [16:0] w_x2;
    logic [16:0] w_r2;
    logic        w_ge1;
    logic        w_ge2;

    always_comb begin
        w_x1  = {r_rem, r_low[31]};
        w_ge1 = w_x1 >= {1'b0, r_div};
        w_r1  = w_ge1 ? w_x1 - {1'b0, r_div} : w_x1;
        w_x2  = {w_r1[15:0], r_low[30]};
        w_ge2 = w_x2 >= {1'b0, r_div};
        w_r2  = w_ge2 ? w_x2 - {1'b0, r_div} : w_x2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.pairs;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem_init;
            r_low <= i_req.low;
            r_quo <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_r2[15:0];
            r_low <= {r_low[29:0], 2'b00};
            r_quo <= {r_quo[29:0], w_ge1, w_ge2};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    `ASSERT_IMPL(a_no_restart, i_clk, i_rst_n, i_req.start, !r_busy, "divider restarted while busy")
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done && !r_busy, "done not a single pulse")

endmodule

/* rtl/psfg_coef.sv */
// Coefficient unit: entry times gain, scaled to 10000, saturated; three stages.
module psfg_coef (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [psfg_pkg::ENTRY_W-1:0]  i_entry,
    input  logic [psfg_pkg::ENTRY_W-1:0]  i_gain,
    output logic                          o_valid,
    output logic [psfg_pkg::COEF_W-1:0]   o_coef
);
    import psfg_pkg::*;

    logic [2:0]            r_vld;
    logic [21:0]           r_eg;
    logic [35:0]           r_sc;
    logic [COEF_W-1:0]     r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_eg <= {11'b0, i_entry} * {11'b0, i_gain};
        end
        if (r_vld[0]) begin
            r_sc <= {14'b0, r_eg} * {22'b0, COEF_FULL};
        end
        if (r_vld[1]) begin
            r_coef <= (r_sc[35:20] > {2'b0, COEF_FULL}) ? COEF_FULL : r_sc[33:20];
        end
    end

    assign o_valid = r_vld[2];
    assign o_coef  = r_coef;

endmodule

/* rtl/pedal_speed_ffb_gain_core.sv */
// Top level: pedal-driven speed model feeding spring and damper gain lookups.
// A tick request runs through the shared serial divider (two pedal divides, two short
// divides), the gain table reads and the coefficient units; no request is accepted until
// its result is loaded into the output register. Table write requests give no result and
// leave the core ready. Reset (synchronous, active low) loads register defaults and zero
// speed; the gain tables hold no defined contents until written.
`include "assert_macros.svh"

module pedal_speed_ffb_gain_core #(
    parameter int PEDAL_BITS  = 16,
    parameter int TABLE_STEPS = 1000
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // throttle_raw[15:0], brake_raw[31:16], table_index[41:32], table_value[52:42]
    input  logic [55:0]                   s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // spring_coefficient[13:0], damper_coefficient[27:14], vehicle_speed[43:28]
    output logic [47:0]                   m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [psfg_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [psfg_pkg::CFG_DW-1:0]   i_cfg_wdata
);
    import psfg_pkg::*;

    localparam int TS_W = $clog2(TABLE_STEPS + 1);
    localparam logic [15:0] PEDAL_FULL = 16'((1 << PEDAL_BITS) - 1);
    localparam logic [15:0] STEPS_MAX  = 16'(TABLE_STEPS);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_MUL_T = 5'd1;
    localparam logic [4:0] ST_GO_T  = 5'd2;
    localparam logic [4:0] ST_WT_T  = 5'd3;
    localparam logic [4:0] ST_MUL_B = 5'd4;
    localparam logic [4:0] ST_GO_B  = 5'd5;
    localparam logic [4:0] ST_WT_B  = 5'd6;
    localparam logic [4:0] ST_ACC1  = 5'd7;
    localparam logic [4:0] ST_ACC2  = 5'd8;
    localparam logic [4:0] ST_GO_S  = 5'd9;
    localparam logic [4:0] ST_WT_S  = 5'd10;
    localparam logic [4:0] ST_SPEED = 5'd11;
    localparam logic [4:0] ST_MUL_I = 5'd12;
    localparam logic [4:0] ST_GO_I  = 5'd13;
    localparam logic [4:0] ST_WT_I  = 5'd14;
    localparam logic [4:0] ST_RD    = 5'd15;
    localparam logic [4:0] ST_LD    = 5'd16;
    localparam logic [4:0] ST_COEF  = 5'd17;
    localparam logic [4:0] ST_OUT   = 5'd18;

    // configuration
    logic [1:0]         r_pedal_invert;
    logic [15:0]        r_thr_max;
    logic [15:0]        r_brk_max;
    logic [15:0]        r_ground;
    logic [15:0]        r_drag_factor;
    logic [15:0]        r_max_speed;
    logic [10:0]        r_spring_gain;
    logic [10:0]        r_damper_gain;

    // control
    logic [4:0]         r_state;
    logic [4:0]         n_state;
    logic [15:0]        r_speed;
    logic [15:0]        n_speed;
    logic               r_out_valid;
    logic [47:0]        r_out_data;

    // datapath
    logic [15:0]        r_p_thr;
    logic [15:0]        r_p_brk;
    logic [31:0]        r_prod;
    logic [31:0]        r_sq;
    logic [31:0]        r_drag;
    logic [31:0]        r_thr;
    logic [31:0]        r_brk;
    logic [33:0]        r_a;
    logic [34:0]        r_b;
    logic [35:0]        r_n;
    logic [TS_W-1:0]    r_pos;

    logic               w_in_acc;
    logic [1:0]         w_op;
    logic [15:0]        w_thr_raw;
    logic [15:0]        w_brk_raw;
    logic [9:0]         w_tab_idx;
    logic [10:0]        w_tab_val;
    logic               w_idx_ok;
    logic [15:0]        w_thr_sat;
    logic [15:0]        w_brk_sat;
    logic [15:0]        w_thr_p;
    logic [15:0]        w_brk_p;
    logic [47:0]        w_drag_prod;
    logic [19:0]        w_u;
    logic [15:0]        w_top;
    logic [17:0]        w_v;
    logic [15:0]        w_pos;

    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;

    logic [ENTRY_W-1:0] w_spr_entry;
    logic [ENTRY_W-1:0] w_dmp_entry;
    logic               w_spr_valid;
    logic               w_dmp_valid;
    logic [COEF_W-1:0]  w_spr_coef;
    logic [COEF_W-1:0]  w_dmp_coef;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_op          = s_axis_tuser;
    assign w_thr_raw     = s_axis_tdata[15:0];
    assign w_brk_raw     = s_axis_tdata[31:16];
    assign w_tab_idx     = s_axis_tdata[41:32];
    assign w_tab_val     = s_axis_tdata[52:42];
    assign w_idx_ok      = {6'b0, w_tab_idx} <= STEPS_MAX;

    always_comb begin
        w_thr_sat = (w_thr_raw > PEDAL_FULL) ? PEDAL_FULL : w_thr_raw;
        w_brk_sat = (w_brk_raw > PEDAL_FULL) ? PEDAL_FULL : w_brk_raw;
        w_thr_p   = r_pedal_invert[0] ? PEDAL_FULL - w_thr_sat : w_thr_sat;
        w_brk_p   = r_pedal_invert[1] ? PEDAL_FULL - w_brk_sat : w_brk_sat;
    end

    assign w_drag_prod = {32'b0, r_drag_factor} * {16'b0, r_sq};
    assign w_u         = r_n[35:16] + BIAS_NUM;
    assign w_top       = (r_max_speed == 16'd0) ? 16'd1 : r_max_speed;
    assign w_v         = {2'b0, r_speed} + {5'b0, w_div_rsp.quo[12:0]} - DIV_BIAS;
    assign w_pos       = (w_div_rsp.quo > {16'b0, STEPS_MAX}) ? STEPS_MAX
                                                              : w_div_rsp.quo[15:0];

    always_comb begin
        if (w_v[17] || w_v == 18'd0) begin
            n_speed = 16'd0;
        end else if (w_v[16:0] >= {1'b0, w_top}) begin
            n_speed = w_top;
        end else begin
            n_speed = w_v[15:0];
        end
    end

    // divider requests
    always_comb begin
        w_div_req = '0;
        unique case (r_state)
            ST_GO_T, ST_GO_B: begin
                w_div_req.start    = 1'b1;
                w_div_req.rem_init = r_prod[31:16];
                w_div_req.low      = {r_prod[15:0], 16'b0};
                w_div_req.pairs    = PAIRS_PEDAL;
                w_div_req.divisor  = PEDAL_FULL;
            end
            ST_GO_S: begin
                w_div_req.start    = 1'b1;
                w_div_req.rem_init = {10'b0, w_u[19:14]};
                w_div_req.low      = {w_u[13:0], 18'b0};
                w_div_req.pairs    = PAIRS_SHORT;
                w_div_req.divisor  = TICK_HZ;
            end
            ST_GO_I: begin
                w_div_req.start    = 1'b1;
                w_div_req.rem_init = r_prod[29:14];
                w_div_req.low      = {r_prod[13:0], 18'b0};
                w_div_req.pairs    = PAIRS_SHORT;
                w_div_req.divisor  = w_top;
            end
            default: begin
                w_div_req = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_acc && w_op == OP_TICK) n_state = ST_MUL_T;
            ST_MUL_T: n_state = ST_GO_T;
            ST_GO_T:  n_state = ST_WT_T;
            ST_WT_T:  if (w_div_rsp.done) n_state = ST_MUL_B;
            ST_MUL_B: n_state = ST_GO_B;
            ST_GO_B:  n_state = ST_WT_B;
            ST_WT_B:  if (w_div_rsp.done) n_state = ST_ACC1;
            ST_ACC1:  n_state = ST_ACC2;
            ST_ACC2:  n_state = ST_GO_S;
            ST_GO_S:  n_state = ST_WT_S;
            ST_WT_S:  if (w_div_rsp.done) n_state = ST_SPEED;
            ST_SPEED: n_state = ST_MUL_I;
            ST_MUL_I: n_state = ST_GO_I;
            ST_GO_I:  n_state = ST_WT_I;
            ST_WT_I:  if (w_div_rsp.done) n_state = ST_RD;
            ST_RD:    n_state = ST_LD;
            ST_LD:    n_state = ST_COEF;
            ST_COEF:  if (w_spr_valid && w_dmp_valid) n_state = ST_OUT;
            ST_OUT:   if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_speed        <= '0;
            r_out_valid    <= 1'b0;
            r_pedal_invert <= '0;
            r_thr_max      <= RST_THR_MAX;
            r_brk_max      <= RST_BRK_MAX;
            r_ground       <= RST_GROUND;
            r_drag_factor  <= RST_DRAG;
            r_max_speed    <= RST_MAX_SPEED;
            r_spring_gain  <= RST_GAIN;
            r_damper_gain  <= RST_GAIN;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SPEED) begin
                r_speed <= n_speed;
            end
            if (r_state == ST_OUT && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_PEDAL_INVERT: r_pedal_invert <= i_cfg_wdata[1:0];
                    CFG_THR_MAX:      r_thr_max      <= i_cfg_wdata;
                    CFG_BRK_MAX:      r_brk_max      <= i_cfg_wdata;
                    CFG_GROUND:       r_ground       <= i_cfg_wdata;
                    CFG_DRAG:         r_drag_factor  <= i_cfg_wdata;
                    CFG_MAX_SPEED:    r_max_speed    <= i_cfg_wdata;
                    CFG_SPRING_GAIN:  r_spring_gain  <= i_cfg_wdata[10:0];
                    CFG_DAMPER_GAIN:  r_damper_gain  <= i_cfg_wdata[10:0];
                    default:          r_pedal_invert <= r_pedal_invert;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_p_thr <= w_thr_p;
            r_p_brk <= w_brk_p;
        end
        if (r_state == ST_MUL_T) begin
            r_prod <= {16'b0, r_p_thr} * {16'b0, r_thr_max};
            r_sq   <= {16'b0, r_speed} * {16'b0, r_speed};
        end
        if (r_state == ST_WT_T && w_div_rsp.done) begin
            r_thr <= w_div_rsp.quo;
        end
        if (r_state == ST_MUL_B) begin
            r_prod <= {16'b0, r_p_brk} * {16'b0, r_brk_max};
            r_drag <= w_drag_prod[47:16];
        end
        if (r_state == ST_WT_B && w_div_rsp.done) begin
            r_brk <= w_div_rsp.quo;
        end
        if (r_state == ST_ACC1) begin
            r_a <= {2'b0, r_thr} - {2'b0, r_brk};
            r_b <= {3'b0, r_ground, 16'b0} + {3'b0, r_drag} - HALF_STEP;
        end
        if (r_state == ST_ACC2) begin
            r_n <= {{2{r_a[33]}}, r_a} - {r_b[34], r_b};
        end
        if (r_state == ST_MUL_I) begin
            r_prod <= {16'b0, r_speed} * {16'b0, STEPS_MAX};
        end
        if (r_state == ST_WT_I && w_div_rsp.done) begin
            r_pos <= TS_W'(w_pos);
        end
        if (r_state == ST_OUT && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= {4'b0, r_speed, w_dmp_coef, w_spr_coef};
        end
    end

    psfg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    psfg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_STEPS + 1)
    ) u_spring_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_op == OP_WR_SPRING && w_idx_ok),
        .i_waddr (TS_W'(w_tab_idx)),
        .i_wdata (w_tab_val),
        .i_re    (r_state == ST_RD),
        .i_raddr (r_pos),
        .o_rdata (w_spr_entry)
    );

    psfg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_STEPS + 1)
    ) u_damper_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_op == OP_WR_DAMPER && w_idx_ok),
        .i_waddr (TS_W'(w_tab_idx)),
        .i_wdata (w_tab_val),
        .i_re    (r_state == ST_RD),
        .i_raddr (r_pos),
        .o_rdata (w_dmp_entry)
    );

    psfg_coef u_spring_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_state == ST_LD),
        .i_entry (w_spr_entry),
        .i_gain  (r_spring_gain),
        .o_valid (w_spr_valid),
        .o_coef  (w_spr_coef)
    );

    psfg_coef u_damper_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_state == ST_LD),
        .i_entry (w_dmp_entry),
        .i_gain  (r_damper_gain),
        .o_valid (w_dmp_valid),
        .o_coef  (w_dmp_coef)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `ASSERT_NEXT(a_speed_bound, i_clk, i_rst_n, r_state == ST_SPEED, r_speed <= $past(w_top), "speed above top speed")
    `ASSERT_IMPL(a_read_range, i_clk, i_rst_n, r_state == ST_RD, 16'(r_pos) <= STEPS_MAX, "table read out of range")
    `ASSERT_IMPL(a_result_src, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == ST_OUT, "result without tick")

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for pedal_speed_ffb_gain_core: random stream traffic against a local speed/gain predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psfg_pkg::*;

    localparam logic [1:0] OP_IGNORED    = 2'd3;
    localparam int         GAIN_STEPS    = 1000;
    localparam longint     PEDAL_FULL    = 65535;
    localparam longint     SPEED_DIV     = 200 * 65536;
    localparam int         IDLE_GUARD    = 100;
    localparam int         RANDOM_PHASES = 10;
    localparam int         PHASE_ITEMS   = 155;
    localparam int         CYCLE_LIMIT   = 3000000;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] thr;
        logic [15:0] brk;
        logic [9:0]  idx;
        logic [10:0] val;
    } pedal_req_t;

    typedef struct packed {
        logic [13:0] spring;
        logic [13:0] damper;
        logic [15:0] speed;
    } gain_res_t;

    typedef struct {
        logic [1:0]  invert;
        logic [15:0] thr_max;
        logic [15:0] brk_max;
        logic [15:0] ground;
        logic [15:0] drag;
        logic [15:0] top;
        logic [10:0] spring_gain;
        logic [10:0] damper_gain;
    } settings_t;

    typedef enum {RUN_THROTTLE, RUN_BRAKE, RUN_COAST, RUN_NOISE} run_style_t;
    typedef enum {RX_ALWAYS, RX_COIN, RX_BLOCKS} rx_mode_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;  // throttle, brake, table_index, table_value from bit 0
    logic [1:0]  s_axis_tuser = '0;  // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;       // spring, damper, vehicle_speed from bit 0
    logic               i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]  i_cfg_addr = '0;
    logic [CFG_DW-1:0]  i_cfg_wdata = '0;

    pedal_speed_ffb_gain_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // predictor state and register mirror
    logic [1:0]  cfg_invert = 2'd0;
    logic [15:0] cfg_thr = RST_THR_MAX;
    logic [15:0] cfg_brk = RST_BRK_MAX;
    logic [15:0] cfg_gnd = RST_GROUND;
    logic [15:0] cfg_drag = RST_DRAG;
    logic [15:0] cfg_top = RST_MAX_SPEED;
    logic [10:0] cfg_spring_gain = RST_GAIN;
    logic [10:0] cfg_damper_gain = RST_GAIN;
    logic [15:0] cur_speed = 16'd0;
    logic [10:0] spring_tab [0:GAIN_STEPS];
    logic [10:0] damper_tab [0:GAIN_STEPS];

    pedal_req_t pending_reqs[$];
    gain_res_t  expected_gains[$];
    pedal_req_t cur_req;
    gain_res_t  want;
    logic       req_loaded = 1'b0;
    logic       drain_hold = 1'b0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         errors = 0;
    int         cycle_count = 0;
    rx_mode_t   rx_mode = RX_ALWAYS;
    int         mode_left = 0;
    int         stall_left = 0;
    logic       rx_ready;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint pedal_accel(input logic [15:0] raw, input logic inv,
                                           input logic [15:0] amax);
        longint p;
        p = longint'(raw);
        if (inv) p = PEDAL_FULL - p;
        return ((p * longint'(amax)) <<< 16) / PEDAL_FULL;
    endfunction

    function automatic logic [13:0] gain_coef(input logic [10:0] entry, input logic [10:0] gain);
        longint c;
        c = (longint'(entry) * longint'(COEF_FULL) * longint'(gain)) >>> 20;
        if (c > longint'(COEF_FULL)) c = longint'(COEF_FULL);
        return c[13:0];
    endfunction

    function automatic void predict_request(input pedal_req_t r);
        longint    acc;
        longint    num;
        longint    step;
        longint    nxt;
        longint    top;
        longint    pos;
        gain_res_t g;
        case (r.op)
            OP_WR_SPRING: begin
                if (r.idx <= GAIN_STEPS) spring_tab[r.idx] = r.val;
            end
            OP_WR_DAMPER: begin
                if (r.idx <= GAIN_STEPS) damper_tab[r.idx] = r.val;
            end
            OP_TICK: begin
                acc = pedal_accel(r.thr, cfg_invert[0], cfg_thr)
                    - pedal_accel(r.brk, cfg_invert[1], cfg_brk)
                    - (longint'(cfg_gnd) <<< 16)
                    - ((longint'(cfg_drag) * longint'(cur_speed) * longint'(cur_speed)) >>> 16);
                // round to nearest, halves up, floor on negatives
                num = acc + SPEED_DIV / 2;
                if (num >= 0) step = num / SPEED_DIV;
                else step = -((-num + SPEED_DIV - 1) / SPEED_DIV);
                top = (cfg_top == 16'd0) ? 1 : longint'(cfg_top);
                nxt = longint'(cur_speed) + step;
                if (nxt >= top) nxt = top;
                if (nxt < 0) nxt = 0;
                cur_speed = nxt[15:0];
                pos = (nxt * GAIN_STEPS) / top;
                if (pos > GAIN_STEPS) pos = GAIN_STEPS;
                g.spring = gain_coef(spring_tab[pos], cfg_spring_gain);
                g.damper = gain_coef(damper_tab[pos], cfg_damper_gain);
                g.speed = cur_speed;
                expected_gains.push_back(g);
            end
            default: ;
        endcase
    endfunction

    function automatic logic [10:0] rand_entry();
        if ($urandom_range(0, 9) == 0) return 11'($urandom_range(1025, 2047));
        return 11'($urandom_range(0, 1024));
    endfunction

    task automatic queue_tick(input logic [15:0] thr, input logic [15:0] brk);
        pedal_req_t r;
        r.op = OP_TICK;
        r.thr = thr;
        r.brk = brk;
        r.idx = 10'($urandom);
        r.val = 11'($urandom);
        pending_reqs.push_back(r);
    endtask

    task automatic queue_table_write(input logic [1:0] op, input logic [9:0] idx,
                                     input logic [10:0] val);
        pedal_req_t r;
        r.op = op;
        r.thr = 16'($urandom);
        r.brk = 16'($urandom);
        r.idx = idx;
        r.val = val;
        pending_reqs.push_back(r);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= value;
        case (addr)
            CFG_PEDAL_INVERT: cfg_invert = value[1:0];
            CFG_THR_MAX:      cfg_thr = value;
            CFG_BRK_MAX:      cfg_brk = value;
            CFG_GROUND:       cfg_gnd = value;
            CFG_DRAG:         cfg_drag = value;
            CFG_MAX_SPEED:    cfg_top = value;
            CFG_SPRING_GAIN:  cfg_spring_gain = value[10:0];
            CFG_DAMPER_GAIN:  cfg_damper_gain = value[10:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int phase);
        settings_t s;
        case (phase)
            1: s = '{2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 11'd2047, 11'd2047};
            2: s = '{2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 11'd0, 11'd0};
            3: s = '{2'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd1, 11'd1024, 11'd1024};
            4: s = '{2'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd200, 16'hFFFF, 11'd1024, 11'd777};
            default: begin
                s.invert = 2'($urandom_range(0, 3));
                s.thr_max = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(1000, 20000));
                s.brk_max = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(1000, 20000));
                s.ground = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
                s.drag = 16'($urandom);
                s.top = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 3000))
                                                    : 16'($urandom_range(1, 65535));
                s.spring_gain = ($urandom_range(0, 3) == 0) ? 11'($urandom)
                                                            : 11'($urandom_range(0, 1024));
                s.damper_gain = ($urandom_range(0, 3) == 0) ? 11'($urandom)
                                                            : 11'($urandom_range(0, 1024));
            end
        endcase
        write_reg(CFG_PEDAL_INVERT, 16'(s.invert));
        write_reg(CFG_THR_MAX, s.thr_max);
        write_reg(CFG_BRK_MAX, s.brk_max);
        write_reg(CFG_GROUND, s.ground);
        write_reg(CFG_DRAG, s.drag);
        write_reg(CFG_MAX_SPEED, s.top);
        write_reg(CFG_SPRING_GAIN, 16'(s.spring_gain));
        write_reg(CFG_DAMPER_GAIN, 16'(s.damper_gain));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_random_items(input int count);
        int          made;
        int          len;
        int          sel;
        run_style_t  style;
        logic [15:0] thr;
        logic [15:0] brk;
        logic [9:0]  idx;
        made = 0;
        while (made < count) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                len = $urandom_range(2, 30);
                style = run_style_t'($urandom_range(0, 3));
                repeat (len) begin
                    case (style)
                        RUN_THROTTLE: begin
                            thr = 16'($urandom_range(50000, 65535));
                            brk = 16'($urandom_range(0, 3000));
                        end
                        RUN_BRAKE: begin
                            thr = 16'($urandom_range(0, 3000));
                            brk = 16'($urandom_range(30000, 65535));
                        end
                        RUN_COAST: begin
                            thr = 16'($urandom_range(0, 20000));
                            brk = 16'($urandom_range(0, 20000));
                        end
                        default: begin
                            thr = 16'($urandom);
                            brk = 16'($urandom);
                        end
                    endcase
                    queue_tick(thr, brk);
                end
                made += len;
            end else if (sel < 92) begin
                idx = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(1001, 1023))
                                                  : 10'($urandom_range(0, GAIN_STEPS));
                queue_table_write($urandom_range(0, 1) ? OP_WR_SPRING : OP_WR_DAMPER, idx,
                                  rand_entry());
                made++;
            end else begin
                queue_table_write(OP_IGNORED, 10'($urandom), 11'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_loaded || expected_gains.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_GUARD) @(posedge i_clk);
    endtask

    // request driver: bursts with random gaps, occasional hold until results drain
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_loaded = 1'b0;
            burst_left = 0;
            gap_left = 0;
            drain_hold = 1'b0;
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_request(cur_req);
                req_loaded = 1'b0;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5, 6, 7: gap_left = $urandom_range(1, 8);
                        default:    gap_left = $urandom_range(10, 100);
                    endcase
                    drain_hold = ($urandom_range(0, 15) == 0);
                end
            end
            if (drain_hold && expected_gains.size() == 0) drain_hold = 1'b0;
            if (!req_loaded) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (!drain_hold && pending_reqs.size() != 0) begin
                    cur_req = pending_reqs.pop_front();
                    req_loaded = 1'b1;
                    s_axis_tdata <= {3'b000, cur_req.val, cur_req.idx, cur_req.brk, cur_req.thr};
                    s_axis_tuser <= cur_req.op;
                end
            end
            s_axis_tvalid <= req_loaded;
        end
    end

    // result stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(100, 600);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_ALWAYS: rx_ready = 1'b1;
                RX_COIN:   rx_ready = 1'($urandom);
                default: begin
                    if (stall_left != 0) begin
                        stall_left--;
                        rx_ready = 1'b0;
                    end else begin
                        rx_ready = 1'b1;
                        if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 60);
                    end
                end
            endcase
            m_axis_tready <= rx_ready;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_gains.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = expected_gains.pop_front();
                if (m_axis_tdata[13:0] !== want.spring) begin
                    $display("%0t: spring expected %0d actual %0d", $time, want.spring,
                             m_axis_tdata[13:0]);
                    errors++;
                end
                if (m_axis_tdata[27:14] !== want.damper) begin
                    $display("%0t: damper expected %0d actual %0d", $time, want.damper,
                             m_axis_tdata[27:14]);
                    errors++;
                end
                if (m_axis_tdata[43:28] !== want.speed) begin
                    $display("%0t: speed expected %0d actual %0d", $time, want.speed,
                             m_axis_tdata[43:28]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every entry is loaded before the first tick reads one
        for (int i = 0; i <= GAIN_STEPS; i++) begin
            queue_table_write(OP_WR_SPRING, 10'(i), rand_entry());
            queue_table_write(OP_WR_DAMPER, 10'(i), rand_entry());
        end

        queue_table_write(OP_WR_SPRING, 10'd0, 11'd2047);
        queue_table_write(OP_WR_DAMPER, 10'd0, 11'd0);
        queue_table_write(OP_WR_SPRING, 10'd1000, 11'd1024);
        queue_table_write(OP_WR_DAMPER, 10'd1000, 11'd2047);
        queue_table_write(OP_WR_SPRING, 10'd1001, 11'd7);
        queue_table_write(OP_WR_DAMPER, 10'd1023, 11'd1);
        queue_table_write(OP_IGNORED, 10'd5, 11'd5);
        queue_tick(16'h0000, 16'h0000);
        queue_tick(16'h0000, 16'hFFFF);
        queue_tick(16'hFFFF, 16'hFFFF);
        repeat (8) queue_tick(16'hFFFF, 16'h0000);
        queue_tick(16'h8000, 16'h7FFF);
        repeat (3) queue_tick(16'h0000, 16'hFFFF);
        wait_drained();

        for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
            apply_settings(ph);
            queue_random_items(PHASE_ITEMS);
            wait_drained();
        end

        if (errors == 0 && expected_gains.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
